/* hw/rtl/itoa_pkg.sv */
`default_nettype none

package itoa_pkg;

  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;
  localparam int CHAR_W      = 8;
  localparam int MAX_CHARS   = 5;
  localparam int CNT_W       = 3;
  localparam int VALUE_W     = 16;
  localparam int CMD_W       = 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam int          QUO_W       = 32 - DIV10_SHIFT;

  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_A = 8'h61;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR = 2'd0,
    CMD_DEC  = 2'd1,
    CMD_HEX2 = 2'd2,
    CMD_HEX4 = 2'd3
  } cmd_t;

  // one formatted run, chars in printing order
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]                 count;
  } entry_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = ASCII_0 + {4'b0, nib};
    end else begin
      r = ASCII_A + {4'b0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/itoa_front.sv */
`default_nettype none

module itoa_front
  import itoa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output logic                      push_valid,
  output entry_t                    push_entry,
  input  wire logic                 fifo_full
);

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } fsm_t;

  fsm_t                   state;
  logic [1:0]             step;
  logic [QUO_W-1:0]       work;
  logic [3:0][3:0]        digits;
  logic                   is_dec;
  entry_t                 ent;

  logic                   acc;
  logic                   push_go;
  cmd_t                   cmd;
  logic [VALUE_W-1:0]     value;
  logic [VALUE_W-1:0]     mul_in;
  logic [31:0]            prod;
  logic [QUO_W-1:0]       quo;
  logic [3:0]             rem;
  entry_t                 class_entry;
  entry_t                 dec_entry;
  logic [MAX_CHARS-1:0][3:0] dig;
  logic [CNT_W-1:0]       nd;
  logic [CNT_W-1:0]       sel;

  assign cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
  assign value = s_tdata[CMD_W +: VALUE_W];

  assign push_valid = (state == FS_PUSH);
  assign push_go    = push_valid && !fifo_full;
  assign s_tready   = (state == FS_IDLE) || push_go;
  assign acc        = s_tvalid && s_tready;

  // one divide-by-ten step per cycle, least significant digit first
  assign mul_in = acc ? value : {{(VALUE_W-QUO_W){1'b0}}, work};
  assign prod   = {16'b0, mul_in} * {16'b0, DIV10_MUL};
  assign quo    = prod[31:DIV10_SHIFT];
  assign rem    = 4'(mul_in - {quo, 3'b000} - {2'b00, quo, 1'b0});

  always_comb begin
    class_entry       = '0;
    class_entry.chars = '0;
    unique case (cmd)
      CMD_CHAR: begin
        class_entry.chars[0] = value[7:0];
        class_entry.count    = 3'd1;
      end
      CMD_DEC: begin
        class_entry.count = 3'd1;
      end
      CMD_HEX2: begin
        class_entry.chars[0] = hex_char(value[7:4]);
        class_entry.chars[1] = hex_char(value[3:0]);
        class_entry.count    = 3'd2;
      end
      CMD_HEX4: begin
        class_entry.chars[0] = hex_char(value[15:12]);
        class_entry.chars[1] = hex_char(value[11:8]);
        class_entry.chars[2] = hex_char(value[7:4]);
        class_entry.chars[3] = hex_char(value[3:0]);
        class_entry.count    = 3'd4;
      end
      default: begin
        class_entry.count = 3'd1;
      end
    endcase
  end

  // decimal run: drop leading zeros, reverse into printing order
  always_comb begin
    dig[0] = digits[0];
    dig[1] = digits[1];
    dig[2] = digits[2];
    dig[3] = digits[3];
    dig[4] = work[3:0];
    if (dig[4] != 4'd0) begin
      nd = 3'd5;
    end else if (dig[3] != 4'd0) begin
      nd = 3'd4;
    end else if (dig[2] != 4'd0) begin
      nd = 3'd3;
    end else if (dig[1] != 4'd0) begin
      nd = 3'd2;
    end else begin
      nd = 3'd1;
    end
    dec_entry.count = nd;
    for (int k = 0; k < MAX_CHARS; k++) begin
      sel = nd - 3'd1 - 3'(k);
      if (3'(k) < nd) begin
        dec_entry.chars[k] = ASCII_0 + {4'b0, dig[sel]};
      end else begin
        dec_entry.chars[k] = ASCII_0;
      end
    end
  end

  assign push_entry = is_dec ? dec_entry : ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      unique case (state)
        FS_IDLE: begin
          if (acc) begin
            state <= (cmd == CMD_DEC) ? FS_DIV : FS_PUSH;
          end
        end
        FS_DIV: begin
          if (step == 2'd3) begin
            state <= FS_PUSH;
          end
        end
        FS_PUSH: begin
          if (acc) begin
            state <= (cmd == CMD_DEC) ? FS_DIV : FS_PUSH;
          end else if (push_go) begin
            state <= FS_IDLE;
          end
        end
        default: begin
          state <= FS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      is_dec    <= (cmd == CMD_DEC);
      ent       <= class_entry;
      digits[0] <= rem;
      work      <= quo;
      step      <= 2'd1;
    end else if (state == FS_DIV) begin
      digits[step] <= rem;
      work         <= quo;
      step         <= step + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/itoa_fifo.sv */
`default_nettype none

module itoa_fifo
  import itoa_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  input  wire entry_t push_entry,
  output logic        full,
  output logic        head_valid,
  output entry_t      head,
  input  wire logic   pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] DEPTH_C  = CNT_W_Q'(DEPTH);

  entry_t               mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W_Q-1:0]   fill;
  logic                 wr_en;
  logic                 rd_en;

  assign full       = (fill == DEPTH_C);
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];
  assign wr_en      = push_valid && !full;
  assign rd_en      = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_W_Q'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_W_Q'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/itoa_back.sv */
`default_nettype none

module itoa_back
  import itoa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire entry_t               head,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic                      m_tlast
);

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             is_last;

  assign load    = !m_tvalid || m_tready;
  assign is_last = (idx == head.count - 3'd1);
  assign pop     = load && head_valid && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        idx <= is_last ? '0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      m_tdata <= head.chars[idx];
      m_tlast <= is_last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter.sv */
// path: an item goes from the front end through the queue into the output register;
// a decimal item first takes four divide-by-ten steps on one shared multiplier
// throughput: the output port sends one character per cycle while m_tready is high and
// the queue holds characters; an item has 1, 2 or 4 characters, or 1 to 5 for decimal;
// the decimal front end takes no new item while it is still dividing
// reset: synchronous, clears the front state, the queue and the output valid
`default_nettype none

module integer_to_ascii_formatter
  import itoa_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // command[1:0], value[17:2], zero pad
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // character[7:0]
  output logic                      m_tlast
);

  logic   push_valid;
  entry_t push_entry;
  logic   fifo_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  itoa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .fifo_full  (fifo_full)
  );

  itoa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  itoa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

/* hw/rtl/itoa_checker.sv */
`default_nettype none

module itoa_checker
  import itoa_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic                 m_tlast
);

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] open_items;
  logic [2:0] run_len;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // items taken in whose final character has not gone out yet
  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
      run_len    <= '0;
    end else begin
      if (in_xfer && !(out_xfer && m_tlast)) begin
        open_items <= open_items + 4'd1;
      end else if (!in_xfer && out_xfer && m_tlast) begin
        open_items <= open_items - 4'd1;
      end
      if (out_xfer) begin
        run_len <= m_tlast ? 3'd0 : run_len + 3'd1;
      end
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> open_items != 4'd0)
    else $error("character sent with no item outstanding");

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    out_xfer && run_len == 3'd4 |-> m_tlast)
    else $error("run longer than five characters");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import itoa_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          LONG_HOLD   = 80;
  localparam int          TAIL_CYCLES = 20;
  localparam logic [7:0]  CH_ZERO     = 8'h30;
  localparam logic [7:0]  CH_LOWER_A  = 8'h61;

  // expected characters of every accepted request, oldest first
  class char_run_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } out_char_t;

    out_char_t pending_chars[$];
    int        errors = 0;

    function logic [7:0] nibble_ascii(input logic [3:0] nib);
      if (nib < 4'd10) return CH_ZERO + {4'b0, nib};
      return CH_LOWER_A + {4'b0, nib} - 8'd10;
    endfunction

    function void note_request(input cmd_t cmd, input logic [15:0] value);
      logic [7:0]  run_chars[$];
      int unsigned rest;
      int unsigned divisor;
      int unsigned digit;
      bit          started;
      out_char_t   item;
      case (cmd)
        CMD_CHAR: run_chars.push_back(value[7:0]);
        CMD_DEC: begin
          rest = {16'b0, value};
          divisor = 10000;
          started = 1'b0;
          if (rest == 0) begin
            run_chars.push_back(CH_ZERO);
          end else begin
            while (divisor > 0) begin
              digit = rest / divisor;
              rest = rest % divisor;
              if (digit != 0 || started) begin
                run_chars.push_back(CH_ZERO + digit[7:0]);
                started = 1'b1;
              end
              divisor = divisor / 10;
            end
          end
        end
        CMD_HEX2: begin
          run_chars.push_back(nibble_ascii(value[7:4]));
          run_chars.push_back(nibble_ascii(value[3:0]));
        end
        default: begin
          run_chars.push_back(nibble_ascii(value[15:12]));
          run_chars.push_back(nibble_ascii(value[11:8]));
          run_chars.push_back(nibble_ascii(value[7:4]));
          run_chars.push_back(nibble_ascii(value[3:0]));
        end
      endcase
      foreach (run_chars[i]) begin
        item.ch = run_chars[i];
        item.last = (i == run_chars.size() - 1);
        pending_chars.push_back(item);
      end
    endfunction

    function void check_char(input logic [7:0] ch, input logic last);
      out_char_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got char %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: character mismatch: expected %h, got %h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last flag mismatch: expected %b, got %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  char_run_scoreboard sb = new();

  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  bit          no_idle = 1'b0;
  int unsigned rx_run = 0;
  int unsigned rx_stall = 0;
  int unsigned cycles = 0;

  integer_to_ascii_formatter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: ready runs and stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_run <= 0;
      rx_stall <= 0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      rx_stall <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_run != 0) begin
      m_tready <= 1'b1;
      rx_run <= rx_run - 1;
    end else begin
      m_tready <= 1'b1;
      rx_run <= $urandom_range(1, 16);
      rx_stall <= no_idle ? 0 : gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_request(cmd_t'(s_tdata[CMD_W-1:0]), s_tdata[CMD_W +: VALUE_W]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_char(m_tdata, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [15:0] value);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_W - VALUE_W - CMD_W){1'b0}}, value, cmd};
    do @(posedge clk); while (!s_tready);
    gap = no_idle ? 0 : gap_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // start at a falling edge so the last transfer is already noted
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random();
    cmd_t        cmd;
    logic [15:0] value;
    cmd = cmd_t'($urandom_range(0, 3));
    value = 16'($urandom_range(0, 65535));
    // spread decimal values over all digit counts
    if (cmd == CMD_DEC && $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 4))
        0: value = 16'($urandom_range(0, 9));
        1: value = 16'($urandom_range(10, 99));
        2: value = 16'($urandom_range(100, 999));
        3: value = 16'($urandom_range(1000, 9999));
        default: value = 16'($urandom_range(10000, 65535));
      endcase
    end
    send_request(cmd, value);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(CMD_CHAR, 16'h0000);
    send_request(CMD_CHAR, 16'h00ff);
    send_request(CMD_CHAR, 16'hff25);
    send_request(CMD_DEC, 16'd0);
    send_request(CMD_DEC, 16'd9);
    send_request(CMD_DEC, 16'd10);
    send_request(CMD_DEC, 16'd99);
    send_request(CMD_DEC, 16'd100);
    send_request(CMD_DEC, 16'd9999);
    send_request(CMD_DEC, 16'd10000);
    send_request(CMD_DEC, 16'd12345);
    send_request(CMD_DEC, 16'd60007);
    send_request(CMD_DEC, 16'd65535);
    send_request(CMD_HEX2, 16'h0000);
    send_request(CMD_HEX2, 16'h12ab);
    send_request(CMD_HEX2, 16'hffff);
    send_request(CMD_HEX4, 16'h0000);
    send_request(CMD_HEX4, 16'hffff);
    send_request(CMD_HEX4, 16'h9a0f);
    send_request(CMD_HEX4, 16'hbcde);
    send_request(CMD_HEX4, 16'h5a5a);

    repeat (80) send_random();

    // sender pause, then a long receiver hold while requests keep coming
    wait_drained();
    hold_asked <= hold_asked + 1;
    no_idle <= 1'b1;
    repeat (20) send_random();
    repeat (60) send_random();
    no_idle <= 1'b0;
    repeat (70) send_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
